FILE: hdl/delayed_link_byte_shaper_defines.svh
// Assertion macros for the link byte shaper.
// Used by the top level only; no other dependencies.
`ifndef DELAYED_LINK_BYTE_SHAPER_DEFINES_SVH
`define DELAYED_LINK_BYTE_SHAPER_DEFINES_SVH
`define DLBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DLBS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: hdl/dlbs_pkg.sv
// Shared types and constants for the link byte shaper.
// No dependencies.
package dlbs_pkg;
  localparam int QueueDepth = 16;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [47:0] TickGapMs = 48'd10;
  localparam logic [2:0] KIND_ACCEPT = 3'd0;
  localparam logic [2:0] KIND_DROP = 3'd1;
  localparam logic [2:0] KIND_RELEASE = 3'd2;
  localparam logic [2:0] KIND_CLOSED = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;
  localparam logic [1:0] REG_CLOSE = 2'd0;
  localparam logic [1:0] REG_SHAPE = 2'd1;
  localparam logic [1:0] REG_BPM = 2'd2;
  typedef struct packed {
    logic        req_type;
    logic [47:0] now_ms;
    logic        to_server;
    logic [16:0] chunk_len;
  } in_item_t;
  typedef struct packed {
    logic [2:0]  kind;
    logic        release_to_server;
    logic [16:0] release_len;
    logic        last;
  } out_item_t;
endpackage

FILE: hdl/dlbs_if.sv
// Valid/ready channel interfaces for the link byte shaper.
// Depends on dlbs_pkg.
interface dlbs_in_if;
  logic valid;
  logic ready;
  dlbs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dlbs_out_if;
  logic valid;
  logic ready;
  dlbs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/dlbs_front.sv
// Front part: accepts items into a two-entry queue for the back part.
// Depends on dlbs_pkg.
module dlbs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dlbs_pkg::in_item_t  in_data_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output dlbs_pkg::in_item_t  q_data_o
);
  dlbs_pkg::in_item_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push;
  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rd_q];
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

FILE: hdl/dlbs_back.sv
// Back part: FIFOs, idle and tick logic, release sequencer and output register.
// Depends on dlbs_pkg.
module dlbs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [30:0]         close_period_i,
  input  logic                shaping_i,
  input  logic [23:0]         bpm_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  output logic                q_retire_o,
  input  dlbs_pkg::in_item_t  q_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dlbs_pkg::out_item_t out_data_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_SRV = 3'd2;
  localparam logic [2:0] S_CLI = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam int P = dlbs_pkg::PtrW;
  localparam int C = dlbs_pkg::CntW;

  logic [47:0] stime [2][dlbs_pkg::QueueDepth];
  logic [16:0] slen [2][dlbs_pkg::QueueDepth];
  logic [P-1:0] head_q [2];
  logic [C-1:0] cnt_q [2];
  logic [47:0] last_act_q, last_tick_q, now_q, elapsed_q;
  logic closed_q, rel_q, unl_q;
  logic [2:0] st_q;
  logic [64:0] used_q;
  logic [63:0] budget_q;
  logic ov_valid_q;
  dlbs_pkg::out_item_t ov_q;

  logic can_out, sel;
  logic [P-1:0] h, tail;
  logic [47:0] ht;
  logic [16:0] hl;
  logic [64:0] used_n;
  logic fits;
  logic [71:0] prod;
  logic timeout, tick_ok, tick_start, full, rel_ok, load_out;
  logic [2:0] idle_kind;
  assign can_out = !ov_valid_q || out_ready_i;
  assign out_valid_o = ov_valid_q;
  assign out_data_o = ov_q;
  assign sel = (st_q == S_SRV);
  assign h = head_q[sel];
  assign ht = stime[sel][h];
  assign hl = slen[sel][h];
  assign used_n = used_q + {48'd0, hl};
  assign fits = unl_q || (used_n <= {1'b0, budget_q});
  assign prod = elapsed_q * {24'd0, bpm_i};
  assign tail = head_q[q_data_i.to_server] + cnt_q[q_data_i.to_server][P-1:0];
  assign timeout = q_data_i.now_ms > last_act_q &&
                   q_data_i.now_ms - last_act_q > {17'd0, close_period_i};
  assign tick_ok = !shaping_i || (q_data_i.now_ms > last_tick_q &&
                   q_data_i.now_ms - last_tick_q > dlbs_pkg::TickGapMs);
  assign tick_start = !closed_q && q_data_i.req_type && !timeout && tick_ok;
  assign full = (cnt_q[q_data_i.to_server] == C'(dlbs_pkg::QueueDepth));
  assign idle_kind = closed_q ? dlbs_pkg::KIND_CLOSED :
                     !q_data_i.req_type ?
                       (full ? dlbs_pkg::KIND_DROP : dlbs_pkg::KIND_ACCEPT) :
                     timeout ? dlbs_pkg::KIND_CLOSED : dlbs_pkg::KIND_DONE;
  assign q_pop_o = (st_q == S_IDLE) && q_valid_i && can_out && !tick_start;
  assign q_retire_o = (st_q == S_DONE) && can_out;
  assign rel_ok = (cnt_q[sel] != '0) && (ht <= now_q) && fits;
  assign load_out = q_pop_o || q_retire_o ||
                    ((st_q == S_SRV || st_q == S_CLI) && can_out && rel_ok);

  always_ff @(posedge clk_i) begin
    if (q_pop_o && !closed_q && !q_data_i.req_type &&
        cnt_q[q_data_i.to_server] != C'(dlbs_pkg::QueueDepth)) begin
      stime[q_data_i.to_server][tail] <= q_data_i.now_ms;
      slen[q_data_i.to_server][tail] <= q_data_i.chunk_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q[0] <= '0; head_q[1] <= '0;
      cnt_q[0] <= '0; cnt_q[1] <= '0;
      last_act_q <= '0; last_tick_q <= '0; closed_q <= 1'b0;
      st_q <= S_IDLE; ov_valid_q <= 1'b0; rel_q <= 1'b0; unl_q <= 1'b0;
      now_q <= '0; elapsed_q <= '0; used_q <= '0; budget_q <= '0; ov_q <= '0;
    end else begin
      ov_valid_q <= load_out || (ov_valid_q && !out_ready_i);
      unique case (st_q)
        S_IDLE: begin
          if (q_valid_i && can_out) begin
            now_q <= q_data_i.now_ms;
            elapsed_q <= q_data_i.now_ms - last_tick_q;
            rel_q <= 1'b0;
            used_q <= '0;
            if (tick_start) begin
              unl_q <= !shaping_i || (bpm_i == 24'd0);
              st_q <= shaping_i ? S_MUL : S_SRV;
            end else begin
              ov_q <= '{kind: idle_kind, release_to_server: 1'b0,
                        release_len: 17'd0, last: 1'b1};
              if (!closed_q && !q_data_i.req_type) begin
                last_act_q <= q_data_i.now_ms;
                if (!full) begin
                  cnt_q[q_data_i.to_server] <= cnt_q[q_data_i.to_server] + 1'b1;
                end
              end else if (!closed_q && q_data_i.req_type && timeout) begin
                closed_q <= 1'b1;
              end
            end
          end
        end
        S_MUL: begin
          budget_q <= (prod[71:64] != 8'd0) ? {64{1'b1}} : prod[63:0];
          st_q <= S_SRV;
        end
        S_SRV, S_CLI: begin
          if (can_out) begin
            if (rel_ok) begin
              ov_q <= '{kind: dlbs_pkg::KIND_RELEASE, release_to_server: sel,
                        release_len: hl, last: 1'b0};
              used_q <= used_n;
              head_q[sel] <= h + 1'b1;
              cnt_q[sel] <= cnt_q[sel] - 1'b1;
              rel_q <= 1'b1;
            end else begin
              used_q <= '0;
              st_q <= sel ? S_CLI : S_DONE;
            end
          end
        end
        S_DONE: begin
          if (can_out) begin
            ov_q <= '{kind: dlbs_pkg::KIND_DONE, release_to_server: 1'b0,
                      release_len: 17'd0, last: 1'b1};
            if (rel_q) last_act_q <= now_q;
            if (shaping_i) last_tick_q <= now_q;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/dlbs_pop.sv
// Pop generator: merges the early pop with the retire of a finished update item.
// Depends on nothing beyond its ports.
module dlbs_pop (
  input  logic early_pop_i,
  input  logic retire_i,
  output logic pop_o
);
  assign pop_o = early_pop_i || retire_i;
endmodule

FILE: hdl/delayed_link_byte_shaper.sv
// Link byte shaper: top level with configuration registers and channel plumbing.
// Depends on dlbs_pkg, dlbs_if, dlbs_front, dlbs_back, dlbs_pop and the defines header.
// Items arrive on in_ch and results leave on out_ch, both valid/ready.
// A write on cfg_we_i stores cfg_wdata_i into the register chosen by cfg_idx_i.
// An arrival or a closed-link item gives one result, through the front queue and the output register.
// An update that is due for a tick computes the byte budget first if shaping is on,
// then walks the to-server queue and then the to-client queue one release per cycle
// while the output is not stalled, and ends with an update-done result; other
// updates give a single closed or update-done result.
// The release sequencer with its single output register paces the update.
// An update stays in the two-entry front queue until it finishes, so one more
// item can wait behind it.
// A stalled receiver holds the output register and the sequencer waits.
// Reset empties both chunk queues, clears the idle and tick times and reopens
// the link; registers return to close period 600000, shaping off, budget zero.
`include "delayed_link_byte_shaper_defines.svh"
module delayed_link_byte_shaper (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [30:0]  cfg_wdata_i,
  dlbs_in_if.sink      in_ch,
  dlbs_out_if.source   out_ch
);
  logic [30:0] close_q;
  logic shape_q;
  logic [23:0] bpm_q;
  logic qv, pop_back, retire, pop;
  dlbs_pkg::in_item_t qd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_q <= 31'd600000;
      shape_q <= 1'b0;
      bpm_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dlbs_pkg::REG_CLOSE: close_q <= cfg_wdata_i;
        dlbs_pkg::REG_SHAPE: shape_q <= cfg_wdata_i[0];
        dlbs_pkg::REG_BPM: bpm_q <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  dlbs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_data_i(in_ch.data),
    .q_valid_o(qv), .q_pop_i(pop), .q_data_o(qd)
  );

  dlbs_back u_back (
    .clk_i, .rst_ni,
    .close_period_i(close_q), .shaping_i(shape_q), .bpm_i(bpm_q),
    .q_valid_i(qv), .q_pop_o(pop_back), .q_retire_o(retire), .q_data_i(qd),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_o(out_ch.data)
  );

  dlbs_pop u_pop (
    .early_pop_i(pop_back), .retire_i(retire), .pop_o(pop)
  );

  `DLBS_ASSERT(a_pop_needs_item, clk_i, rst_ni, pop |-> qv, "pop from empty queue")
  `DLBS_ASSERT(a_release_not_last, clk_i, rst_ni, (out_ch.valid && out_ch.data.kind == dlbs_pkg::KIND_RELEASE) |-> !out_ch.data.last, "release marked last")
  `DLBS_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> !out_ch.valid, "output valid after reset")
endmodule

FILE: sim/tb_delayed_link_byte_shaper.sv
// Testbench for the link byte shaper: directed and random items on the valid/ready channels.
// A behavioral predictor of both chunk queues checks every result in order.
// Depends on dlbs_pkg, dlbs_if and the delayed_link_byte_shaper top level.
module tb_delayed_link_byte_shaper;
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [30:0] cfg_wdata_i;

  dlbs_in_if  in_ch ();
  dlbs_out_if out_ch ();

  delayed_link_byte_shaper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  localparam int SettleCycles = 60;
  localparam int StallLimit   = 5000;

  // Shaper state as predicted; index 1 is the to-server queue, 0 the to-client queue.
  logic [47:0] chunk_time [2][dlbs_pkg::QueueDepth];
  logic [16:0] chunk_len_q [2][dlbs_pkg::QueueDepth];
  int          q_head [2];
  int          q_count [2];
  logic [47:0] idle_since_ms;
  logic [47:0] tick_at_ms;
  logic        closed_flag;
  logic [30:0] close_ms;
  logic        shape_on;
  logic [23:0] budget_rate;

  dlbs_pkg::out_item_t pending_results [$];
  int          fails;
  int          stall_cycles;
  int          rx_gap;
  int          rx_hold;
  bit          no_idle;
  logic [47:0] clock_ms;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic dlbs_pkg::out_item_t make_result(logic [2:0] k, logic d, logic [16:0] l,
                                                      logic lst);
    dlbs_pkg::out_item_t r;
    r.kind = k;
    r.release_to_server = d;
    r.release_len = l;
    r.last = lst;
    return r;
  endfunction

  task automatic release_due(int dir, logic [47:0] now, logic [63:0] budget, ref int released);
    logic [63:0] spent;
    int          h;
    spent = 64'd0;
    while (q_count[dir] > 0) begin
      h = q_head[dir];
      if (chunk_time[dir][h] > now) break;
      if (budget != 64'd0) begin
        spent = spent + 64'(chunk_len_q[dir][h]);
        if (budget < spent) break;
      end
      pending_results.push_back(make_result(dlbs_pkg::KIND_RELEASE, dir[0],
                                            chunk_len_q[dir][h], 1'b0));
      released++;
      q_head[dir] = (h + 1) % dlbs_pkg::QueueDepth;
      q_count[dir]--;
    end
  endtask

  task automatic predict_item(dlbs_pkg::in_item_t it);
    int          dir;
    int          t;
    int          released;
    bit          tick;
    logic [63:0] budget;
    logic [47:0] elapsed;
    logic [71:0] product;
    released = 0;
    tick = 1'b0;
    budget = 64'd0;
    if (closed_flag) begin
      pending_results.push_back(make_result(dlbs_pkg::KIND_CLOSED, 1'b0, 17'd0, 1'b1));
    end else if (!it.req_type) begin
      dir = it.to_server ? 1 : 0;
      idle_since_ms = it.now_ms;
      if (q_count[dir] >= dlbs_pkg::QueueDepth) begin
        pending_results.push_back(make_result(dlbs_pkg::KIND_DROP, 1'b0, 17'd0, 1'b1));
      end else begin
        t = (q_head[dir] + q_count[dir]) % dlbs_pkg::QueueDepth;
        chunk_time[dir][t] = it.now_ms;
        chunk_len_q[dir][t] = it.chunk_len;
        q_count[dir]++;
        pending_results.push_back(make_result(dlbs_pkg::KIND_ACCEPT, 1'b0, 17'd0, 1'b1));
      end
    end else if (it.now_ms > idle_since_ms &&
                 (it.now_ms - idle_since_ms) > {17'd0, close_ms}) begin
      closed_flag = 1'b1;
      pending_results.push_back(make_result(dlbs_pkg::KIND_CLOSED, 1'b0, 17'd0, 1'b1));
    end else begin
      if (shape_on) begin
        if (it.now_ms > tick_at_ms && (it.now_ms - tick_at_ms) > dlbs_pkg::TickGapMs) begin
          elapsed = it.now_ms - tick_at_ms;
          product = 72'(elapsed) * 72'(budget_rate);
          budget = (product[71:64] != 8'd0) ? {64{1'b1}} : product[63:0];
          tick = 1'b1;
        end
      end else begin
        tick = 1'b1;
      end
      if (tick) begin
        release_due(1, it.now_ms, budget, released);
        release_due(0, it.now_ms, budget, released);
        if (released > 0) idle_since_ms = it.now_ms;
        if (shape_on) tick_at_ms = it.now_ms;
      end
      pending_results.push_back(make_result(dlbs_pkg::KIND_DONE, 1'b0, 17'd0, 1'b1));
    end
  endtask

  task automatic send_item(dlbs_pkg::in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(it);
  endtask

  task automatic send_arrival(logic [47:0] now, logic dir, logic [16:0] len);
    dlbs_pkg::in_item_t it;
    it.req_type = 1'b0;
    it.now_ms = now;
    it.to_server = dir;
    it.chunk_len = len;
    send_item(it);
  endtask

  task automatic send_update(logic [47:0] now);
    dlbs_pkg::in_item_t it;
    it.req_type = 1'b1;
    it.now_ms = now;
    it.to_server = 1'($urandom_range(0, 1));
    it.chunk_len = 17'($urandom());
    send_item(it);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      dlbs_pkg::REG_CLOSE: close_ms = value;
      dlbs_pkg::REG_SHAPE: shape_on = value[0];
      dlbs_pkg::REG_BPM:   budget_rate = value[23:0];
      default: ;
    endcase
  endtask

  task automatic test_unshaped_release();
    write_reg(dlbs_pkg::REG_CLOSE, 31'h7FFF_FFFF);
    write_reg(dlbs_pkg::REG_SHAPE, 31'd0);
    write_reg(dlbs_pkg::REG_BPM, 31'd0);
    send_arrival(48'd0, 1'b1, 17'd1);
    send_arrival(48'd0, 1'b0, 17'd0);
    send_arrival(48'd1, 1'b1, 17'h1FFFF);
    send_update(48'd1);
    // The clock steps back here: the later chunk is not due yet.
    send_arrival(48'd5, 1'b0, 17'd77);
    send_update(48'd3);
    send_update(48'd6);
    wait_idle();
  endtask

  task automatic test_full_queues();
    for (int i = 0; i < dlbs_pkg::QueueDepth; i++) send_arrival(48'd10, 1'b0, 17'(i + 1));
    for (int i = 0; i <= dlbs_pkg::QueueDepth; i++) send_arrival(48'd10, 1'b1, 17'(100 + i));
    send_update(48'd10);
    wait_idle();
  endtask

  task automatic test_budget();
    write_reg(dlbs_pkg::REG_SHAPE, 31'd1);
    write_reg(dlbs_pkg::REG_BPM, 31'd100);
    send_arrival(48'd20, 1'b1, 17'd300);
    send_arrival(48'd20, 1'b0, 17'd300);
    send_update(48'd25);
    send_arrival(48'd30, 1'b1, 17'd600);
    send_arrival(48'd30, 1'b1, 17'd600);
    send_arrival(48'd30, 1'b1, 17'd100);
    send_update(48'd35);
    send_update(48'd36);
    send_update(48'd60);
    wait_idle();
    write_reg(dlbs_pkg::REG_BPM, 31'd0);
    send_update(48'd80);
    wait_idle();
  endtask

  task automatic test_budget_saturation();
    write_reg(dlbs_pkg::REG_BPM, 31'hFF_FFFF);
    send_arrival(48'hFFFF_FFF0_0000, 1'b1, 17'h1FFFF);
    send_arrival(48'hFFFF_FFF0_0000, 1'b0, 17'h15555);
    send_update(48'hFFFF_FFF0_0000);
    wait_idle();
    clock_ms = 48'hFFFF_FFF0_0000;
  endtask

  task automatic run_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5 && clock_ms > 48'd5) clock_ms = clock_ms - 48'($urandom_range(1, 5));
      else clock_ms = clock_ms + 48'($urandom_range(0, 15));
      if (pick < 65) send_arrival(clock_ms, 1'($urandom_range(0, 1)), 17'($urandom()));
      else send_update(clock_ms);
    end
  endtask

  task automatic test_random_phases();
    write_reg(dlbs_pkg::REG_SHAPE, 31'd0);
    run_random(20);
    wait_idle();
    write_reg(dlbs_pkg::REG_SHAPE, 31'd1);
    write_reg(dlbs_pkg::REG_BPM, 31'd9000);
    no_idle = 1'b1;
    run_random(15);
    no_idle = 1'b0;
    run_random(10);
    wait_idle();
    write_reg(dlbs_pkg::REG_BPM, 31'd0);
    run_random(20);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_reg(dlbs_pkg::REG_SHAPE, 31'd0);
    rx_hold = 300;
    no_idle = 1'b1;
    for (int i = 0; i < 24; i++) begin
      clock_ms = clock_ms + 48'd1;
      if (i % 4 == 3) send_update(clock_ms);
      else send_arrival(clock_ms, 1'(i % 2), 17'($urandom()));
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_link_close();
    write_reg(dlbs_pkg::REG_CLOSE, 31'd0);
    send_arrival(clock_ms, 1'b1, 17'd5);
    send_update(clock_ms);
    wait_idle();
    write_reg(dlbs_pkg::REG_CLOSE, 31'd5);
    send_update(clock_ms + 48'd6);
    send_arrival(clock_ms + 48'd7, 1'b0, 17'd9);
    send_update(clock_ms + 48'd8);
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    dlbs_pkg::out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, out_ch.data.kind);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_ch.data.kind);
          fails++;
        end
        if (out_ch.data.release_to_server !== want.release_to_server) begin
          $display("%0t: release_to_server expected %0d actual %0d", $time,
                   want.release_to_server, out_ch.data.release_to_server);
          fails++;
        end
        if (out_ch.data.release_len !== want.release_len) begin
          $display("%0t: release_len expected %0d actual %0d", $time,
                   want.release_len, out_ch.data.release_len);
          fails++;
        end
        if (out_ch.data.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_ch.data.last);
          fails++;
        end
      end
      rx_gap = no_idle ? 0 : $urandom_range(0, 11);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = dlbs_pkg::REG_CLOSE;
    cfg_wdata_i = 31'd0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    fails = 0;
    stall_cycles = 0;
    rx_gap = 0;
    rx_hold = 0;
    no_idle = 1'b0;
    clock_ms = 48'd0;
    q_head = '{0, 0};
    q_count = '{0, 0};
    idle_since_ms = 48'd0;
    tick_at_ms = 48'd0;
    closed_flag = 1'b0;
    close_ms = 31'd600000;
    shape_on = 1'b0;
    budget_rate = 24'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);
    test_unshaped_release();
    test_full_queues();
    test_budget();
    test_budget_saturation();
    test_random_phases();
    test_backpressure();
    test_link_close();
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
